@@ rtl/pdsc_pkg.sv @@
// Package for the PLL divider setting calculator.
// Holds shared constants, the register index codes and the divider cell record.
// No dependencies.
package pdsc_pkg;

  // Register index codes of the configuration port.
  typedef enum logic [2:0] {
    REG_PARENT_RATE  = 3'd0,
    REG_MAX_RATE     = 3'd1,
    REG_MIN_VCO_RATE = 3'd2,
    REG_PCW_BITS     = 3'd3,
    REG_PCW_INT_BITS = 3'd4
  } reg_idx_e;

  localparam int unsigned NumW   = 64;
  localparam int unsigned DivW   = 32;
  localparam int unsigned ExpW   = 3;
  localparam int unsigned DivLen = NumW;

  localparam logic [DivW-1:0] DefaultMinVco  = 32'd1000000000;
  localparam logic [4:0]      DefaultIntBits = 5'd7;
  localparam logic [ExpW-1:0] LastExp        = 3'd4;

  localparam logic [31:0] ResetParentRate = 32'd26000000;
  localparam logic [31:0] ResetMaxRate    = 32'd3800000000;
  localparam logic [31:0] ResetMinVco     = 32'd1500000000;
  localparam logic [5:0]  ResetPcwBits    = 6'd22;
  localparam logic [4:0]  ResetPcwIntBits = 5'd8;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic            valid;
    logic [NumW-1:0] num;
    logic [DivW-1:0] rem;
    logic [DivW-1:0] quo;
    logic [ExpW-1:0] k;
  } div_t;

endpackage

@@ rtl/pdsc_div_cell.sv @@
// One restoring division cell: retires one quotient bit per item.
// Depends on pdsc_pkg.
module pdsc_div_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pdsc_pkg::DivW-1:0] divisor_i,
  input  pdsc_pkg::div_t           cell_i,
  output pdsc_pkg::div_t           cell_o
);

  logic [pdsc_pkg::DivW:0]   trial;
  logic                      ge;
  logic [pdsc_pkg::DivW:0]   diff;
  pdsc_pkg::div_t            cell_d;
  pdsc_pkg::div_t            cell_q;

  // Shift in the next numerator bit and try to subtract the divisor.
  always_comb begin
    trial = {cell_i.rem, cell_i.num[pdsc_pkg::NumW-1]};
    ge    = (trial >= {1'b0, divisor_i});
    diff  = trial - {1'b0, divisor_i};
    cell_d.valid = cell_i.valid;
    cell_d.num   = {cell_i.num[pdsc_pkg::NumW-2:0], 1'b0};
    cell_d.rem   = ge ? diff[pdsc_pkg::DivW-1:0] : trial[pdsc_pkg::DivW-1:0];
    cell_d.quo   = {cell_i.quo[pdsc_pkg::DivW-2:0], ge};
    cell_d.k     = cell_i.k;
  end

  // The whole record is registered; reset clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

  // A valid item leaves the cell in the cycle after it enters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_i.valid |=> cell_o.valid)
    else $error("div cell dropped an item");

  // The remainder stays below a nonzero divisor once it started below it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_i.valid && divisor_i != '0 && cell_i.rem < divisor_i) |=>
      (cell_o.rem < $past(divisor_i)))
    else $error("div cell remainder out of range");

  // A zero divisor always yields a one quotient bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_i.valid && divisor_i == '0) |=> cell_o.quo[0])
    else $error("div cell zero divisor bit");

endmodule

@@ rtl/pll_divider_setting_calc_top.sv @@
// Top level of the PLL divider setting calculator.
// A request passes the clamp, numerator, division chain, multiply, round and output registers to done_o.
// Throughput: one request per cycle; busy stays low and results cannot be stalled.
// The bulk of the pipeline is the 64-cell restoring division chain, one quotient bit per cell.
// Reset clears all pipeline valid flags and loads the default register values.
// Depends on pdsc_pkg and pdsc_div_cell.
module pll_divider_setting_calc_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] target_rate_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [31:0] pcw_o,
  output logic [2:0]  postdiv_log2_o,
  output logic [63:0] actual_rate_o
);

  // Configuration registers.
  logic [31:0] parent_rate_q, max_rate_q, min_vco_q;
  logic [5:0]  pcw_bits_q;
  logic [4:0]  pcw_int_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parent_rate_q  <= pdsc_pkg::ResetParentRate;
      max_rate_q     <= pdsc_pkg::ResetMaxRate;
      min_vco_q      <= pdsc_pkg::ResetMinVco;
      pcw_bits_q     <= pdsc_pkg::ResetPcwBits;
      pcw_int_bits_q <= pdsc_pkg::ResetPcwIntBits;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pdsc_pkg::REG_PARENT_RATE:  parent_rate_q  <= cfg_wdata_i;
        pdsc_pkg::REG_MAX_RATE:     max_rate_q     <= cfg_wdata_i;
        pdsc_pkg::REG_MIN_VCO_RATE: min_vco_q      <= cfg_wdata_i;
        pdsc_pkg::REG_PCW_BITS:     pcw_bits_q     <= cfg_wdata_i[5:0];
        pdsc_pkg::REG_PCW_INT_BITS: pcw_int_bits_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Derived settings; the user must keep them stable while items are in flight, the block does not enforce it.
  logic [5:0]  int_bits;
  logic [5:0]  fbits;
  logic [31:0] fmin;

  always_comb begin
    int_bits = {1'b0, (pcw_int_bits_q != '0) ? pcw_int_bits_q : pdsc_pkg::DefaultIntBits};
    fbits    = (pcw_bits_q > int_bits) ? (pcw_bits_q - int_bits) : 6'd0;
    fmin     = (min_vco_q != '0) ? min_vco_q : pdsc_pkg::DefaultMinVco;
  end

  assign busy = 1'b0;

  // Stage 1: clamp the request.
  logic        s1_valid_q;
  logic [31:0] s1_freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_freq_q <= (target_rate_i > max_rate_q) ? max_rate_q : target_rate_i;
  end

  // Stage 2: pick the smallest post-divider and build the numerator.
  logic [2:0]  k_sel;
  logic [6:0]  total;
  logic [63:0] num_d;

  always_comb begin
    k_sel = pdsc_pkg::LastExp;
    for (int e = 4; e >= 0; e--) begin
      if (({5'd0, s1_freq_q} << e) >= {5'd0, fmin}) begin
        k_sel = 3'(e);
      end
    end
    total = {4'd0, k_sel} + {1'b0, fbits};
    num_d = total[6] ? 64'd0 : ({32'd0, s1_freq_q} << total[5:0]);
  end

  pdsc_pkg::div_t chain [pdsc_pkg::DivLen+1];
  pdsc_pkg::div_t s2_d;
  pdsc_pkg::div_t s2_q;

  always_comb begin
    s2_d.valid = s1_valid_q;
    s2_d.num   = num_d;
    s2_d.rem   = '0;
    s2_d.quo   = '0;
    s2_d.k     = k_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= s2_d;
    end
  end

  assign chain[0] = s2_q;

  // Division chain: one quotient bit per cell.
  for (genvar i = 0; i < pdsc_pkg::DivLen; i++) begin : g_cell
    pdsc_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (parent_rate_q),
      .cell_i    (chain[i]),
      .cell_o    (chain[i+1])
    );
  end

  pdsc_pkg::div_t div_out;
  assign div_out = chain[pdsc_pkg::DivLen];

  // Stage: multiply parent rate by the word.
  logic        m_valid_q;
  logic [63:0] m_prod_q;
  logic [31:0] m_pcw_q;
  logic [2:0]  m_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= div_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m_prod_q <= {32'd0, parent_rate_q} * {32'd0, div_out.quo};
    m_pcw_q  <= div_out.quo;
    m_k_q    <= div_out.k;
  end

  // Stage: drop fraction bits with round-up.
  logic [63:0] fmask;
  logic [63:0] vco_d;
  logic        r_valid_q;
  logic [63:0] r_vco_q;
  logic [31:0] r_pcw_q;
  logic [2:0]  r_k_q;

  always_comb begin
    fmask = (64'd1 << fbits) - 64'd1;
    vco_d = (m_prod_q >> fbits) + {63'd0, |(m_prod_q & fmask)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_vco_q <= vco_d;
    r_pcw_q <= m_pcw_q;
    r_k_q   <= m_k_q;
  end

  // Output stage: ceiling divide by the post-divider.
  logic [63:0] kmask;
  logic [63:0] ach_d;
  logic        o_valid_q;
  logic [63:0] o_ach_q;
  logic [31:0] o_pcw_q;
  logic [2:0]  o_k_q;

  always_comb begin
    kmask = (64'd1 << r_k_q) - 64'd1;
    ach_d = (r_vco_q >> r_k_q) + {63'd0, |(r_vco_q & kmask)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_ach_q <= ach_d;
    o_pcw_q <= r_pcw_q;
    o_k_q   <= r_k_q;
  end

  assign done_o         = o_valid_q;
  assign pcw_o          = o_pcw_q;
  assign postdiv_log2_o = o_k_q;
  assign actual_rate_o  = o_ach_q;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the PLL divider setting calculator.
// Drives random and corner-case frequency requests, predicts each result and compares.
// Depends on pdsc_pkg and pll_divider_setting_calc_top.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LatencyCycles = 69;

  // Expected result of one request.
  typedef struct packed {
    logic [31:0] pcw;
    logic [2:0]  postdiv_log2;
    logic [63:0] actual_rate;
  } pll_setting_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] target_rate;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  logic        done;
  logic [31:0] pcw;
  logic [2:0]  postdiv_log2;
  logic [63:0] actual_rate;

  // Predictor copy of the registers.
  logic [31:0] parent_rate_q;
  logic [31:0] max_rate_q;
  logic [31:0] min_vco_q;
  logic [5:0]  pcw_bits_q;
  logic [4:0]  pcw_int_bits_q;

  logic [31:0]  pending_rates[$];
  pll_setting_t expected_settings[$];
  int           mismatch_count;
  bit           feeding_paused;
  int           burst_left;
  int           gap_left;

  pll_divider_setting_calc_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .target_rate_i  (target_rate),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .done_o         (done),
    .pcw_o          (pcw),
    .postdiv_log2_o (postdiv_log2),
    .actual_rate_o  (actual_rate)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Computes the divider setting reached for one requested frequency.
  function automatic pll_setting_t calc_pll_setting(logic [31:0] req);
    pll_setting_t res;
    logic [63:0]  vco_floor;
    logic [31:0]  freq;
    logic [4:0]   int_bits;
    logic [6:0]   fbits;
    logic [2:0]   k;
    logic [7:0]   total;
    logic [63:0]  num;
    logic [63:0]  quo;
    logic [63:0]  vco;
    logic         round_up;
    vco_floor = (min_vco_q == 32'd0) ? 64'(pdsc_pkg::DefaultMinVco) : 64'(min_vco_q);
    freq = (req > max_rate_q) ? max_rate_q : req;
    int_bits = (pcw_int_bits_q == 5'd0) ? pdsc_pkg::DefaultIntBits : pcw_int_bits_q;
    fbits = (pcw_bits_q > 6'(int_bits)) ? 7'(pcw_bits_q - 6'(int_bits)) : 7'd0;
    k = pdsc_pkg::LastExp;
    for (int e = 4; e >= 0; e--) begin
      if ((64'(freq) << e) >= vco_floor) k = 3'(e);
    end
    total = 8'(k) + 8'(fbits);
    num = (total >= 8'd64) ? 64'd0 : (64'(freq) << total);
    quo = (parent_rate_q == 32'd0) ? '1 : num / 64'(parent_rate_q);
    res.pcw = quo[31:0];
    vco = 64'(parent_rate_q) * 64'(res.pcw);
    if (fbits != 7'd0) begin
      round_up = (vco & ((64'd1 << fbits) - 64'd1)) != 64'd0;
      vco = (vco >> fbits) + 64'(round_up);
    end
    round_up = (vco & ((64'd1 << k) - 64'd1)) != 64'd0;
    res.actual_rate = (vco >> k) + 64'(round_up);
    res.postdiv_log2 = k;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Request driver: bursts of transfers with random gaps, paused on request.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start <= 1'b0;
      target_rate <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_settings.push_back(calc_pll_setting(target_rate));
      end
      if (start && busy) begin
        // Hold the current request until it is taken.
      end else if (feeding_paused || pending_rates.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        target_rate <= pending_rates.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    pll_setting_t want;
    if (rst_n && done) begin
      if (expected_settings.size() == 0) begin
        report_mismatch("unexpected result pcw", 64'(pcw), 64'd0);
      end else begin
        want = expected_settings.pop_front();
        if (pcw !== want.pcw) report_mismatch("pcw", 64'(pcw), 64'(want.pcw));
        if (postdiv_log2 !== want.postdiv_log2) begin
          report_mismatch("postdiv_log2", 64'(postdiv_log2), 64'(want.postdiv_log2));
        end
        if (actual_rate !== want.actual_rate) begin
          report_mismatch("actual_rate", actual_rate, want.actual_rate);
        end
      end
    end
  end

  // Writes one register on the configuration port and in the predictor.
  task automatic write_reg(pdsc_pkg::reg_idx_e idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pdsc_pkg::REG_PARENT_RATE:  parent_rate_q = value;
      pdsc_pkg::REG_MAX_RATE:     max_rate_q = value;
      pdsc_pkg::REG_MIN_VCO_RATE: min_vco_q = value;
      pdsc_pkg::REG_PCW_BITS:     pcw_bits_q = value[5:0];
      pdsc_pkg::REG_PCW_INT_BITS: pcw_int_bits_q = value[4:0];
      default: ;
    endcase
  endtask

  // Waits for the driver to drain and every expected result to arrive.
  task automatic wait_drained();
    while (pending_rates.size() != 0 || start || expected_settings.size() != 0) begin
      @(posedge clk);
    end
    repeat (LatencyCycles + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] random_rate();
    case ($urandom_range(4, 0))
      0: return $urandom();
      1: return $urandom_range(1600000000, 50000000);
      2: return $urandom_range(4000000000, 1000000000);
      3: return 32'(1) << $urandom_range(31, 0);
      default: return $urandom_range(120000000, 0);
    endcase
  endfunction

  task automatic random_phase(int count);
    repeat (count) pending_rates.push_back(random_rate());
  endtask

  initial begin
    logic [31:0] directed[$];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = pdsc_pkg::REG_PARENT_RATE;
    cfg_wdata = '0;
    mismatch_count = 0;
    feeding_paused = 1'b0;
    parent_rate_q = pdsc_pkg::ResetParentRate;
    max_rate_q = pdsc_pkg::ResetMaxRate;
    min_vco_q = pdsc_pkg::ResetMinVco;
    pcw_bits_q = pdsc_pkg::ResetPcwBits;
    pcw_int_bits_q = pdsc_pkg::ResetPcwIntBits;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on reset settings: extremes, clamp, each divider, no divider.
    directed = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'd3800000000, 32'd3800000001,
                 32'd1500000000, 32'd1499999999, 32'd750000000, 32'd375000000,
                 32'd187500000, 32'd93750000, 32'd93749999, 32'd26000000,
                 32'hAAAAAAAA, 32'h55555555, 32'd100000000};
    foreach (directed[i]) pending_rates.push_back(directed[i]);
    random_phase(250);

    // Pause the sender until everything has come back.
    wait (pending_rates.size() == 0);
    feeding_paused = 1'b1;
    wait_drained();
    feeding_paused = 1'b0;

    // Zero selects defaults; no fraction bits since int bits exceed total.
    write_reg(pdsc_pkg::REG_MIN_VCO_RATE, 32'd0);
    write_reg(pdsc_pkg::REG_PCW_INT_BITS, 5'd0);
    write_reg(pdsc_pkg::REG_PCW_BITS, 6'd5);
    random_phase(250);
    wait_drained();

    // Extremes: widest word, largest limits, huge shift overflow.
    write_reg(pdsc_pkg::REG_PARENT_RATE, 32'hFFFFFFFF);
    write_reg(pdsc_pkg::REG_MAX_RATE, 32'hFFFFFFFF);
    write_reg(pdsc_pkg::REG_MIN_VCO_RATE, 32'hFFFFFFFF);
    write_reg(pdsc_pkg::REG_PCW_BITS, 6'd63);
    write_reg(pdsc_pkg::REG_PCW_INT_BITS, 5'd16);
    pending_rates.push_back(32'hFFFFFFFF);
    pending_rates.push_back(32'd0);
    random_phase(250);
    wait_drained();

    // Zero parent rate gives an all-ones word; tiny clamp and minimum.
    write_reg(pdsc_pkg::REG_PARENT_RATE, 32'd0);
    write_reg(pdsc_pkg::REG_MAX_RATE, 32'd1);
    write_reg(pdsc_pkg::REG_MIN_VCO_RATE, 32'd1);
    write_reg(pdsc_pkg::REG_PCW_BITS, 6'd32);
    write_reg(pdsc_pkg::REG_PCW_INT_BITS, 5'd1);
    random_phase(150);
    wait_drained();

    // Random settings per phase, some with a tiny parent rate.
    repeat (5) begin
      write_reg(pdsc_pkg::REG_PARENT_RATE,
                ($urandom_range(1, 0) != 0) ? $urandom_range(64, 1) : $urandom());
      write_reg(pdsc_pkg::REG_MAX_RATE, $urandom());
      write_reg(pdsc_pkg::REG_MIN_VCO_RATE, $urandom());
      write_reg(pdsc_pkg::REG_PCW_BITS, $urandom_range(40, 1));
      write_reg(pdsc_pkg::REG_PCW_INT_BITS, $urandom_range(31, 0));
      random_phase(150);
      wait_drained();
    end

    // Back to typical settings for the tail.
    write_reg(pdsc_pkg::REG_PARENT_RATE, 32'd26000000);
    write_reg(pdsc_pkg::REG_MAX_RATE, 32'd3800000000);
    write_reg(pdsc_pkg::REG_MIN_VCO_RATE, 32'd1500000000);
    write_reg(pdsc_pkg::REG_PCW_BITS, 6'd22);
    write_reg(pdsc_pkg::REG_PCW_INT_BITS, 5'd8);
    random_phase(200);
    wait_drained();

    if (mismatch_count == 0 && expected_settings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #(20ns * 200000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ pll_divider_setting_calc_top.f @@
rtl/pdsc_pkg.sv
rtl/pdsc_div_cell.sv
rtl/pll_divider_setting_calc_top.sv
dv/tb_top.sv
